FILE: rtl/pit_pkg.sv
// Package for the periodic interval timer: widths, codes, transaction and
// state types, and the value-word packing function. No dependencies.
package pit_pkg;

   localparam int COUNTER_WIDTH  = 20;  // 4..24
   localparam int OVERFLOW_WIDTH = 12;  // 4..12
   localparam int DATA_WIDTH     = 32;
   localparam int EN_BIT         = 24;
   localparam int IE_BIT         = 25;

   localparam logic [COUNTER_WIDTH-1:0]  CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
   localparam logic [OVERFLOW_WIDTH-1:0] OVF_ONE = {{(OVERFLOW_WIDTH-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_IDLE  = 2'd3
   } pit_action_type;

   typedef enum logic [1:0] {
      REG_MODE      = 2'd0,
      REG_STATUS    = 2'd1,
      REG_VALUE_CLR = 2'd2,
      REG_VALUE     = 2'd3
   } pit_reg_type;

   typedef struct packed {
      pit_action_type          action;
      pit_reg_type             reg_index;
      logic [DATA_WIDTH-1:0]   write_data;
   } pit_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  irq;
   } pit_rsp_type;

   typedef struct packed {
      logic [COUNTER_WIDTH-1:0]  interval_value;
      logic                      timer_enable;
      logic                      interrupt_enable;
      logic [COUNTER_WIDTH-1:0]  current_count;
      logic [OVERFLOW_WIDTH-1:0] overflow_count;
      logic                      status_flag;
   } pit_state_type;

   // overflow count above the counter, cut to the bus width
   function automatic logic [DATA_WIDTH-1:0] value_word(
      input logic [COUNTER_WIDTH-1:0]  count,
      input logic [OVERFLOW_WIDTH-1:0] ovf
   );
      logic [63:0] w;
      w = (64'(ovf) << COUNTER_WIDTH) | 64'(count);
      return w[DATA_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/periodic_interval_timer.sv
// Top level of the periodic interval timer: input register, result register
// and handshake control around pit_core. Depends on pit_pkg and pit_core.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   pit_req_type (action, reg_index, write_data)
//   rsp       out        rsp_valid/rsp_stall   pit_rsp_type (read_data, irq)
//
// One transaction per cycle sustained while rsp is not stalled; each gives exactly one
// response, held first in the input register and then in the result register.
// The timer state updates as a transaction leaves the input register, so the
// state register's feedback loop through pit_core sets the rate.
// Reset (synchronous) empties both stages and clears all timer state.
// A stall on rsp holds the result register; the input register still fills,
// and req_stall rises only once both stages are occupied.
module periodic_interval_timer
   import pit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pit_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pit_rsp_type rsp
);

   // input register
   logic        req_valid_ff;
   pit_req_type req_ff;
   // result register
   logic        rsp_valid_ff;
   pit_rsp_type rsp_ff;

   logic          out_ready;  // result register can take a new entry
   logic          fire;       // input register transaction is processed
   pit_rsp_type   core_rsp;
   pit_state_type core_state;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && out_ready;
   assign req_stall = req_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req;
      end
   end

   pit_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_ff),
      .result (core_rsp),
      .state  (core_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // back-pressure only when both stages hold a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("req_stall raised with a free stage");

   // timer state moves only when a transaction is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(core_state))
      else $error("timer state changed without a transaction");

   // read with clear leaves flag and overflow count at zero
   a_read_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_ff.action == ACT_READ) && (req_ff.reg_index == REG_VALUE_CLR))
      |=> (!core_state.status_flag && (core_state.overflow_count == '0)))
      else $error("read with clear did not clear");

   // a stopped timer at rest stays at zero on a tick
   a_rest: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_ff.action == ACT_TICK) && !core_state.timer_enable
       && (core_state.current_count == '0))
      |=> (core_state.current_count == '0))
      else $error("stopped timer advanced from zero");

endmodule

FILE: rtl/pit_core.sv
// Timer state registers and the per-transaction update and register decode.
// Depends on pit_pkg.
module pit_core
   import pit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  pit_req_type   item,
   output pit_rsp_type   result,
   output pit_state_type state
);

   pit_state_type state_ff;
   pit_state_type state_in;

   always_comb begin
      state_in         = state_ff;
      result.read_data = '0;
      case (item.action)
         ACT_TICK: begin
            // runs while enabled; once disabled, runs on until it rests at zero
            if (state_ff.timer_enable || (state_ff.current_count != '0)) begin
               if (state_ff.current_count == state_ff.interval_value) begin
                  state_in.current_count  = '0;
                  state_in.overflow_count = state_ff.overflow_count + OVF_ONE;
                  state_in.status_flag    = 1'b1;
               end else begin
                  state_in.current_count = state_ff.current_count + CNT_ONE;
               end
            end
         end
         ACT_READ: begin
            case (item.reg_index)
               REG_MODE: begin
                  result.read_data[COUNTER_WIDTH-1:0] = state_ff.interval_value;
                  result.read_data[EN_BIT]            = state_ff.timer_enable;
                  result.read_data[IE_BIT]            = state_ff.interrupt_enable;
               end
               REG_STATUS: begin
                  result.read_data[0] = state_ff.status_flag;
               end
               REG_VALUE_CLR: begin
                  result.read_data = value_word(state_ff.current_count,
                                                state_ff.overflow_count);
                  state_in.overflow_count = '0;
                  state_in.status_flag    = 1'b0;
               end
               default: begin
                  result.read_data = value_word(state_ff.current_count,
                                                state_ff.overflow_count);
               end
            endcase
         end
         ACT_WRITE: begin
            if (item.reg_index == REG_MODE) begin
               state_in.interval_value   = item.write_data[COUNTER_WIDTH-1:0];
               state_in.timer_enable     = item.write_data[EN_BIT];
               state_in.interrupt_enable = item.write_data[IE_BIT];
            end
         end
         default: begin
         end
      endcase
      result.irq = state_in.status_flag & state_in.interrupt_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule
